[design/mqsb_pkg.sv]
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and codes for the multi-queue shared slot buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int DATA_W = 32;

  // operation codes carried in tuser
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_ENQUEUED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_DEQUEUED = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  // data word returned for an empty queue
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_LINK,
    S_DONE
  } seq_state_t;

endpackage

[design/multi_queue_shared_buffer_top.sv]
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// Several FIFO queues chained through one shared slot store and a free list.
// ----------------------------------------------------------------------------
// Sequence: accept captures the request, S_READ reads the registered memories,
//   S_EXEC executes, S_LINK follows for an enqueue onto a non-empty queue
//   (second write on the single link memory port), and S_DONE loads the result.
// One word at a time: no new word is taken until its result is loaded.
// Reset (rst, synchronous): all queues empty, free list holds every slot in
//   index order, no result pending. No clearing pass is needed.
module multi_queue_shared_buffer_top #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mqsb_pkg::DATA_W-1:0] s_tdata,  // [31:0] data_in
  input  logic [2:0]                 s_tuser,   // [0] opcode, [2:1] queue_id
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mqsb_pkg::DATA_W-1:0] m_tdata,  // [31:0] data_out
  output logic [1:0]                 m_tuser    // [1:0] status
);

  import mqsb_pkg::*;

  // slot index, link (with null = SLOTS) and queue index widths
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW   = $clog2(SLOTS + 1);
  localparam int QCNT = (QUEUES < 4) ? QUEUES : 4;
  localparam int QIW  = (QCNT > 1) ? $clog2(QCNT) : 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  seq_state_t state, state_next;

  // captured request
  logic              op_r;
  logic [1:0]        q_r;
  logic [DATA_W-1:0] din_r;

  // pointer state
  logic [LW-1:0] queue_head [QCNT];
  logic [LW-1:0] queue_tail [QCNT];
  logic [LW-1:0] free_head;
  logic [LW-1:0] fresh;       // slots at or above this were never allocated

  // slot store
  logic [DATA_W-1:0] slot_data [SLOTS];
  logic [LW-1:0]     slot_link [SLOTS];
  logic [DATA_W-1:0] data_rd;
  logic [LW-1:0]     link_rd;

  // working slot and pending result
  logic [LW-1:0]     cur;
  logic [DATA_W-1:0] res_data;
  status_t           res_status;

  logic [QIW-1:0] qi;
  logic           qok;
  logic [LW-1:0]  sel_ptr;
  logic [LW-1:0]  link_val;
  logic           cur_ok;
  logic           head_ok;
  logic           tail_ok;

  // shared memory write port
  logic          link_we;
  logic [SW-1:0] link_wa;
  logic [LW-1:0] link_wd;
  logic          data_we;

  assign qi       = q_r[QIW-1:0];
  assign qok      = (int'(q_r) < QUEUES);
  assign sel_ptr  = (op_r == OP_DEQ) ? queue_head[qi] : free_head;
  assign cur_ok   = (cur < NIL);
  assign head_ok  = (queue_head[qi] < NIL);
  assign tail_ok  = (queue_tail[qi] < NIL);
  // an untouched slot still links to its successor
  assign link_val = (cur >= fresh) ? (cur + LW'(1)) : link_rd;

  assign s_tready = (state == S_IDLE);

  // sequencer next state and memory write port
  always_comb begin
    state_next = state;
    link_we    = 1'b0;
    link_wa    = cur[SW-1:0];
    link_wd    = NIL;
    data_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (qok && cur_ok) begin
          if (op_r == OP_ENQ) begin
            data_we = 1'b1;
            if (head_ok && tail_ok) begin
              // append after the old tail, null the new slot next cycle
              link_we    = 1'b1;
              link_wa    = queue_tail[qi][SW-1:0];
              link_wd    = cur;
              state_next = S_LINK;
            end else begin
              link_we = 1'b1;
            end
          end else begin
            // push freed slot onto the free list
            link_we = 1'b1;
            link_wd = free_head;
          end
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slot memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (link_we) slot_link[link_wa] <= link_wd;
    if (data_we) slot_data[cur[SW-1:0]] <= din_r;
    link_rd <= slot_link[sel_ptr[SW-1:0]];
    data_rd <= slot_data[sel_ptr[SW-1:0]];
  end

  // capture the request word and the working slot
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r  <= s_tuser[0];
      q_r   <= s_tuser[2:1];
      din_r <= s_tdata;
    end
    if (state == S_READ) cur <= sel_ptr;
  end

  // pointer updates and result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QCNT; i++) begin
        queue_head[i] <= NIL;
        queue_tail[i] <= NIL;
      end
      free_head <= '0;
      fresh     <= '0;
    end else if (state == S_EXEC) begin
      if (op_r == OP_ENQ) begin
        res_data <= '0;
        if (!qok || !cur_ok) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_ENQUEUED;
          free_head  <= link_val;
          if (cur >= fresh) fresh <= fresh + LW'(1);
          if (!head_ok || !tail_ok) queue_head[qi] <= cur;
          queue_tail[qi] <= cur;
        end
      end else begin
        if (!qok || !cur_ok) begin
          res_data   <= EMPTY_VALUE;
          res_status <= ST_EMPTY;
        end else begin
          res_data   <= data_rd;
          res_status <= ST_DEQUEUED;
          free_head  <= cur;
          if (link_val >= NIL) begin
            queue_head[qi] <= NIL;
            queue_tail[qi] <= NIL;
          end else begin
            queue_head[qi] <= link_val;
          end
        end
      end
    end
  end

  // output register: load when free, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= res_data;
      m_tuser <= res_status;
    end
  end

endmodule

[tb/sv/multi_queue_shared_buffer_checker.sv]
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_checker
// Watches both stream channels of the shared slot buffer, tracks the slot
// store, free list and queue chains on every accepted word, and compares each
// result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_checker #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [mqsb_pkg::DATA_W-1:0] s_tdata,     // [31:0] data_in
  input  logic [2:0]                  s_tuser,     // [0] opcode, [2:1] queue_id
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [mqsb_pkg::DATA_W-1:0] m_tdata,     // [31:0] data_out
  input  logic [1:0]                  m_tuser,     // [1:0] status
  output int                          fail_count,
  output int                          pending,
  output int                          n_enqueued,
  output int                          n_dropped,
  output int                          n_dequeued,
  output int                          n_empty
);

  import mqsb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(SLOTS);

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    status_t           status;
  } queue_result_t;

  // shadow copy of the buffer state
  logic [DATA_W-1:0] slot_data [SLOTS];
  logic [IDX_W-1:0]  slot_link [SLOTS];
  logic [IDX_W-1:0]  q_head    [QUEUES];
  logic [IDX_W-1:0]  q_tail    [QUEUES];
  logic [IDX_W-1:0]  free_head;

  queue_result_t due_results[$];

  // Apply one queue operation to the shadow state and return its result word.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic [1:0] qid,
                                                   input logic [DATA_W-1:0] din);
    queue_result_t    r;
    int               q;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] nx;
    q = qid;
    r.data_out = '0;
    if (op == OP_ENQ) begin
      if (q >= QUEUES || free_head >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        // pop a slot off the free list and chain it after the tail
        s = free_head;
        free_head = slot_link[s];
        if (q_head[q] >= SLOTS || q_tail[q] >= SLOTS) begin
          q_head[q] = s;
        end else begin
          slot_link[q_tail[q]] = s;
        end
        slot_link[s] = NIL;
        q_tail[q] = s;
        slot_data[s] = din;
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (q >= QUEUES || q_head[q] >= SLOTS) begin
        r.data_out = EMPTY_VALUE;
        r.status = ST_EMPTY;
      end else begin
        // unlink the head; the last item leaves both ends null
        s = q_head[q];
        nx = slot_link[s];
        if (nx >= SLOTS) begin
          q_head[q] = NIL;
          q_tail[q] = NIL;
        end else begin
          q_head[q] = nx;
        end
        r.data_out = slot_data[s];
        // return the slot to the free list
        slot_link[s] = free_head;
        free_head = s;
        r.status = ST_DEQUEUED;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t exp_word;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_data[i] = '0;
        slot_link[i] = IDX_W'(i + 1);
      end
      slot_link[SLOTS-1] = NIL;
      for (int i = 0; i < QUEUES; i++) begin
        q_head[i] = NIL;
        q_tail[i] = NIL;
      end
      free_head = '0;
      due_results.delete();
      fail_count = 0;
      n_enqueued = 0;
      n_dropped = 0;
      n_dequeued = 0;
      n_empty = 0;
    end else begin
      // check the result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: data_out %0d status %0d",
                 $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          exp_word = due_results.pop_front();
          if (m_tdata !== exp_word.data_out) begin
            $error("data_out: expected %0d, got %0d",
                   $signed(exp_word.data_out), $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, m_tuser);
            fail_count++;
          end
          case (exp_word.status)
            ST_ENQUEUED: n_enqueued++;
            ST_FULL:     n_dropped++;
            ST_DEQUEUED: n_dequeued++;
            default:     n_empty++;
          endcase
        end
      end
      // predict the result of each accepted input word
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_queue_op(s_tuser[0], s_tuser[2:1], s_tdata));
      end
    end
    pending = due_results.size();
  end

endmodule

[tb/sv/multi_queue_shared_buffer_top_tb.sv]
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top_tb
// Drives enqueue and dequeue words into the shared slot buffer with random
// gaps on both channels: a directed opening (empty queues, extreme data,
// filling the store, draining a queue), then phases of random traffic with
// shifting enqueue bias. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top_tb;
  import mqsb_pkg::*;

  localparam int SLOTS       = 16;
  localparam int QUEUES      = 4;
  localparam int PHASES      = 15;
  localparam int PHASE_WORDS = 50;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [31:0] data_in
  logic [2:0]        s_tuser = '0;   // [0] opcode, [2:1] queue_id
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [31:0] data_out
  logic [1:0]        m_tuser;        // [1:0] status

  int  fail_count;
  int  pending;
  int  n_enqueued;
  int  n_dropped;
  int  n_dequeued;
  int  n_empty;
  int  cycles = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  always #1 clk = ~clk;

  multi_queue_shared_buffer_top #(
    .SLOTS (SLOTS),
    .QUEUES(QUEUES)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  multi_queue_shared_buffer_checker #(
    .SLOTS (SLOTS),
    .QUEUES(QUEUES)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .fail_count(fail_count),
    .pending   (pending),
    .n_enqueued(n_enqueued),
    .n_dropped (n_dropped),
    .n_dequeued(n_dequeued),
    .n_empty   (n_empty)
  );

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("multi_queue_shared_buffer_top_tb failed");
      $finish;
    end
  end

  // Present one word, holding it until the block takes it.
  task automatic send_word(input logic op, input logic [1:0] qid,
                           input logic [DATA_W-1:0] din);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom();
      s_tuser <= 3'($urandom());
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {qid, op};
    s_tdata <= din;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // result side: stall a random number of cycles before each word
  initial begin
    int stall;
    @(negedge rst);
    @(negedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic [DATA_W-1:0] edge_data [4];
    int                enq_pct;
    int                focus_q;
    logic [1:0]        qid;
    logic              op;

    edge_data[0] = 32'h7FFF_FFFF;
    edge_data[1] = 32'h8000_0000;
    edge_data[2] = 32'h0000_0000;
    edge_data[3] = 32'hFFFF_FFFF;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // dequeue from every queue while all are empty
    for (int q = 0; q < QUEUES; q++) begin
      send_word(OP_DEQ, 2'(q), $urandom());
    end
    // fill the whole store round-robin, extreme data first
    for (int i = 0; i < SLOTS; i++) begin
      send_word(OP_ENQ, 2'(i % QUEUES), (i < 4) ? edge_data[i] : $urandom());
    end
    // store is full: this one is dropped
    send_word(OP_ENQ, 2'd2, $urandom());
    // drain the top queue until it is empty
    for (int i = 0; i < SLOTS / QUEUES; i++) begin
      send_word(OP_DEQ, 2'd3, $urandom());
    end

    // random traffic, biased toward filling or draining per phase
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 20;
        1: enq_pct = 50;
        default: enq_pct = 80;
      endcase
      focus_q = ($urandom_range(0, 2) == 0) ? $urandom_range(0, QUEUES - 1) : -1;
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        qid = (focus_q >= 0 && $urandom_range(0, 3) != 0) ? 2'(focus_q)
                                                          : 2'($urandom());
        send_word(op, qid, $urandom());
      end
    end
    s_tvalid <= 1'b0;

    // let the remaining results drain, then allow for stray words
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("checked %0d result words over %0d cycles", n_enqueued + n_dropped +
             n_dequeued + n_empty, cycles);
    $display("  %0d enqueued, %0d dropped on full, %0d dequeued, %0d on empty queue",
             n_enqueued, n_dropped, n_dequeued, n_empty);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_queue_shared_buffer_top_tb passed");
    end else begin
      $display("multi_queue_shared_buffer_top_tb failed");
    end
    $finish;
  end

endmodule
